[rtl/tlvfp_pkg.sv]
package tlvfp_pkg;

    // Role of one frame byte; also the phase the parser expects next.
    typedef enum logic [1:0] {
        ROLE_HEADER  = 2'd0,
        ROLE_TYPE    = 2'd1,
        ROLE_LENGTH  = 2'd2,
        ROLE_PAYLOAD = 2'd3
    } role_t;

    localparam logic [7:0] TYPE_KNOWN_A = 8'h01;
    localparam logic [7:0] TYPE_KNOWN_B = 8'h02;
    localparam logic [7:0] TYPE_KNOWN_C = 8'h03;

    localparam int unsigned M_DATA_WIDTH = 24;

    function automatic logic is_known_type(input logic [7:0] t);
        return (t == TYPE_KNOWN_A) || (t == TYPE_KNOWN_B) || (t == TYPE_KNOWN_C);
    endfunction

endpackage

[rtl/tlv_frame_parser.sv]
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata: in_byte
// m_        out        m_tvalid/m_tready  m_tdata: record fields, m_tuser: byte_role,
//                                         m_tlast: frame_end
//
// Every accepted input byte gives exactly one result transfer, from the output register.
// The parser state updates on the same edge that accepts the byte, so a new byte
// may be taken in every cycle; the rate is set by the single output register.
// s_tready is high while that register is empty or being drained by m_tready.
// Reset (rst_n low, asynchronous) returns the parser to expecting a frame header
// and empties the output register.
module tlv_frame_parser
    import tlvfp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [7:0] in_byte
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [7:0] record_type, [8] type_known, [16:9] payload_byte, [17] record_end,
    // [18] truncated, [23:19] zero
    output logic [M_DATA_WIDTH-1:0] m_tdata,
    output logic [1:0]              m_tuser,   // [1:0] byte_role
    output logic                    m_tlast    // frame_end
);

    // Parser state.
    role_t       phase_reg, phase_next;
    logic [7:0]  frame_left_reg, frame_left_next;
    logic [7:0]  record_left_reg, record_left_next;
    logic [7:0]  cur_type_reg, cur_type_next;

    // Output register.
    logic        out_valid_reg;
    logic [1:0]  out_role_reg;
    logic [7:0]  out_type_reg;
    logic        out_known_reg;
    logic [7:0]  out_pay_reg;
    logic        out_rend_reg;
    logic        out_fend_reg;
    logic        out_trunc_reg;

    // Result of the byte on s_tdata, against the current state.
    logic [7:0]  res_type;
    logic        res_known;
    logic [7:0]  res_pay;
    logic        res_rend;
    logic        res_fend;
    logic        res_trunc;
    logic [7:0]  frame_dec;
    logic [7:0]  record_dec;
    logic        accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign frame_dec  = frame_left_reg - 8'd1;
    assign record_dec = record_left_reg - 8'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        frame_left_next  = frame_left_reg;
        record_left_next = record_left_reg;
        cur_type_next    = cur_type_reg;
        res_type         = 8'd0;
        res_known        = 1'b0;
        res_pay          = 8'd0;
        res_rend         = 1'b0;
        res_fend         = 1'b0;
        res_trunc        = 1'b0;

        unique case (phase_reg)
            ROLE_HEADER:
            begin
                // A header of 0 or 1 is a whole, empty frame.
                if (s_tdata <= 8'd1)
                begin
                    res_fend        = 1'b1;
                    frame_left_next = 8'd0;
                end
                else
                begin
                    frame_left_next = s_tdata - 8'd1;
                    phase_next      = ROLE_TYPE;
                end
            end
            ROLE_TYPE:
            begin
                cur_type_next   = s_tdata;
                frame_left_next = frame_dec;
                res_type        = s_tdata;
                res_known       = is_known_type(s_tdata);
                if (frame_dec == 8'd0)
                begin
                    // The frame stops right after a type byte.
                    res_fend   = 1'b1;
                    res_trunc  = 1'b1;
                    phase_next = ROLE_HEADER;
                end
                else
                begin
                    phase_next = ROLE_LENGTH;
                end
            end
            ROLE_LENGTH:
            begin
                record_left_next = s_tdata;
                frame_left_next  = frame_dec;
                res_type         = cur_type_reg;
                res_known        = is_known_type(cur_type_reg);
                res_rend         = (s_tdata == 8'd0);
                if (frame_dec == 8'd0)
                begin
                    res_fend   = 1'b1;
                    res_trunc  = (s_tdata != 8'd0);
                    phase_next = ROLE_HEADER;
                end
                else if (s_tdata == 8'd0)
                begin
                    phase_next = ROLE_TYPE;
                end
                else
                begin
                    phase_next = ROLE_PAYLOAD;
                end
            end
            ROLE_PAYLOAD:
            begin
                record_left_next = record_dec;
                frame_left_next  = frame_dec;
                res_type         = cur_type_reg;
                res_known        = is_known_type(cur_type_reg);
                res_pay          = s_tdata;
                res_rend         = (record_dec == 8'd0);
                if (frame_dec == 8'd0)
                begin
                    res_fend   = 1'b1;
                    res_trunc  = (record_dec != 8'd0);
                    phase_next = ROLE_HEADER;
                end
                else if (record_dec == 8'd0)
                begin
                    phase_next = ROLE_TYPE;
                end
                else
                begin
                    phase_next = ROLE_PAYLOAD;
                end
            end
            default:
            begin
                phase_next = ROLE_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ROLE_HEADER;
            frame_left_reg  <= 8'd0;
            record_left_reg <= 8'd0;
            cur_type_reg    <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                frame_left_reg  <= frame_left_next;
                record_left_reg <= record_left_next;
                cur_type_reg    <= cur_type_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output register; loaded only on an accepted byte.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_role_reg  <= phase_reg;
            out_type_reg  <= res_type;
            out_known_reg <= res_known;
            out_pay_reg   <= res_pay;
            out_rend_reg  <= res_rend;
            out_fend_reg  <= res_fend;
            out_trunc_reg <= res_trunc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_trunc_reg, out_rend_reg, out_pay_reg,
                       out_known_reg, out_type_reg};
    assign m_tuser  = out_role_reg;
    assign m_tlast  = out_fend_reg;

endmodule

[tb/tb_tlv_frame_parser.sv]
`timescale 1ns / 1ps

// Testbench for the byte-serial TLV frame parser. A driver pushes bytes from a
// queue onto the input stream, and a monitor predicts one result per accepted
// byte and checks it against the output stream, in order.
module tb_tlv_frame_parser;
    import tlvfp_pkg::*;

    // One predicted output transfer, field by field.
    typedef struct packed {
        role_t      role;
        logic [7:0] rtype;
        logic       known;
        logic [7:0] payload;
        logic       rec_end;
        logic       frm_end;
        logic       trunc;
    } parse_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata = 8'h00;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_DATA_WIDTH-1:0] m_tdata;
    logic [1:0]              m_tuser;
    logic                    m_tlast;

    tlv_frame_parser i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    logic [7:0]    frame_bytes[$];
    parse_result_t expected_fields[$];
    int            mismatch_count = 0;
    int            src_idle_pct = 0;
    int            rcv_stall_pct = 0;
    logic          src_taken = 1'b0;

    // Shadow copy of the parser state.
    role_t      next_role = ROLE_HEADER;
    logic [7:0] frame_left = 8'h00;
    logic [7:0] record_left = 8'h00;
    logic [7:0] cur_type = 8'h00;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // Appends one byte to the driver's queue.
    task automatic add_byte(input logic [7:0] b);
        frame_bytes = {frame_bytes, b};
    endtask

    // Advances the shadow state by one byte and returns the result it gives.
    function automatic parse_result_t parse_byte(input logic [7:0] b);
        parse_result_t r;
        r = '0;
        r.role = next_role;
        case (next_role)
            ROLE_HEADER:
            begin
                if (b <= 8'd1)
                begin
                    // Empty frame: the header is the whole frame.
                    r.frm_end = 1'b1;
                    frame_left = 8'h00;
                end
                else
                begin
                    frame_left = b - 8'd1;
                    next_role = ROLE_TYPE;
                end
            end
            ROLE_TYPE:
            begin
                cur_type = b;
                frame_left = frame_left - 8'd1;
                if (frame_left == 8'h00)
                begin
                    r.frm_end = 1'b1;
                    r.trunc = 1'b1;
                    next_role = ROLE_HEADER;
                end
                else
                    next_role = ROLE_LENGTH;
            end
            ROLE_LENGTH:
            begin
                record_left = b;
                frame_left = frame_left - 8'd1;
                r.rec_end = (b == 8'h00);
                if (frame_left == 8'h00)
                begin
                    r.frm_end = 1'b1;
                    r.trunc = (b != 8'h00);
                    next_role = ROLE_HEADER;
                end
                else if (b == 8'h00)
                    next_role = ROLE_TYPE;
                else
                    next_role = ROLE_PAYLOAD;
            end
            default:
            begin
                record_left = record_left - 8'd1;
                frame_left = frame_left - 8'd1;
                r.payload = b;
                r.rec_end = (record_left == 8'h00);
                if (frame_left == 8'h00)
                begin
                    r.frm_end = 1'b1;
                    r.trunc = !r.rec_end;
                    next_role = ROLE_HEADER;
                end
                else if (r.rec_end)
                    next_role = ROLE_TYPE;
                else
                    next_role = ROLE_PAYLOAD;
            end
        endcase
        if (r.role != ROLE_HEADER)
        begin
            r.rtype = cur_type;
            r.known = (cur_type == TYPE_KNOWN_A) || (cur_type == TYPE_KNOWN_B) ||
                      (cur_type == TYPE_KNOWN_C);
        end
        return r;
    endfunction

    // Driver: a byte stays on the bus until the edge that takes it.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        if (rst_n && (!s_tvalid || src_taken))
        begin
            if (frame_bytes.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                s_tdata <= frame_bytes.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: predicts on every input transfer, checks every output transfer.
    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n)
        begin
            src_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (expected_fields.size() == 0)
                    report_mismatch("output transfer with no byte outstanding");
                else
                begin
                    want = expected_fields.pop_front();
                    check_field("byte_role", int'(m_tuser), int'(want.role));
                    check_field("record_type", int'(m_tdata[7:0]), int'(want.rtype));
                    check_field("type_known", int'(m_tdata[8]), int'(want.known));
                    check_field("payload_byte", int'(m_tdata[16:9]), int'(want.payload));
                    check_field("record_end", int'(m_tdata[17]), int'(want.rec_end));
                    check_field("truncated", int'(m_tdata[18]), int'(want.trunc));
                    check_field("frame_end", int'(m_tlast), int'(want.frm_end));
                    check_field("pad bits", int'(m_tdata[23:19]), 0);
                end
            end
            if (s_tvalid && s_tready)
                expected_fields = {expected_fields, parse_byte(s_tdata)};
        end
    end

    function automatic logic [7:0] pick_type();
        case ($urandom_range(3))
            0: return TYPE_KNOWN_A;
            1: return TYPE_KNOWN_B;
            2: return TYPE_KNOWN_C;
            default: return 8'($urandom);
        endcase
    endfunction

    // Queues one frame of short records; some are cut short by their header,
    // some are empty, and now and then a stray byte is thrown in.
    task automatic queue_frame();
        logic [7:0] body[$];
        int         n_rec;
        int         len;
        int         keep;
        n_rec = $urandom_range(1, 4);
        for (int i = 0; i < n_rec; i++)
        begin
            len = $urandom_range(0, 6);
            body = {body, pick_type()};
            body = {body, 8'(len)};
            for (int j = 0; j < len; j++)
                body = {body, 8'($urandom)};
        end
        keep = body.size();
        if ($urandom_range(99) < 20)
            keep = $urandom_range(1, body.size() - 1);
        if ($urandom_range(99) < 8)
            add_byte(8'($urandom_range(1)));
        add_byte(8'(keep + 1));
        for (int i = 0; i < keep; i++)
            add_byte(body[i]);
        if ($urandom_range(99) < 5)
            add_byte(8'($urandom));
    endtask

    // Longest possible frame: one record filling it, or overrunning it.
    task automatic queue_long_frame(input bit overrun);
        int len;
        len = overrun ? 255 : 252;
        add_byte(8'hFF);
        add_byte(pick_type());
        add_byte(8'(len));
        for (int i = 0; i < 252; i++)
            add_byte(8'($urandom));
    endtask

    initial
    begin
        int src_pct[4];
        int rcv_pct[4];
        int added;
        int size_mark;
        src_pct = '{0, 66, 0, 14};
        rcv_pct = '{0, 0, 66, 14};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames: both empty headers, a frame ending after its type
        // byte, one ending on a zero length, one ending on a nonzero length,
        // one ending inside a payload, and a zero-length record followed by a
        // complete one.
        frame_bytes = '{8'h00, 8'h01,
                        8'h02, 8'h01,
                        8'h03, 8'h02, 8'h00,
                        8'h03, 8'hFF, 8'h05,
                        8'h05, 8'h02, 8'h03, 8'h00, 8'hFF,
                        8'h06, 8'h80, 8'h00, 8'h03, 8'h01, 8'hAA};

        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct = src_pct[p];
            rcv_stall_pct = rcv_pct[p];
            added = 0;
            if (p == 3)
                queue_long_frame(1'b1);
            while (added < 80)
            begin
                size_mark = frame_bytes.size();
                queue_frame();
                added += frame_bytes.size() - size_mark;
            end
            // Hold the next phase back until every result has come out.
            while (frame_bytes.size() > 0 || s_tvalid || expected_fields.size() > 0)
                @(posedge clk);
        end

        repeat (4) @(posedge clk);
        if (expected_fields.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_fields.size()));
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
